// ===== rtl/core/bscfn_pkg.sv =====
// ----------------------------------------------------------------------------
// bscfn_pkg
// Shared types, command codes and a helper for the bit map with find-next.
// ----------------------------------------------------------------------------
package bscfn_pkg;

	localparam int INDEX_BITS = 13;
	localparam int COUNT_BITS = 14;
	localparam int WORD_BITS  = 64;
	localparam int OFF_BITS   = 6;

	typedef logic [WORD_BITS-1:0]  word_t;
	typedef logic [INDEX_BITS-1:0] index_t;
	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [OFF_BITS-1:0]   off_t;

	typedef enum logic [2:0] {
		CMD_GET       = 3'd0,
		CMD_SET       = 3'd1,
		CMD_CLEAR     = 3'd2,
		CMD_FIND      = 3'd3,
		CMD_CLEAR_ALL = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_RD,
		ST_OP,
		ST_SCAN,
		ST_CLR,
		ST_DONE
	} state_t;

	// lowest set bit position of a word (zero when the word is empty)
	function automatic off_t first_set(word_t w);
		off_t pos;
		pos = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (w[i]) begin
				pos = OFF_BITS'(i);
			end
		end
		return pos;
	endfunction

endpackage

// ===== rtl/core/bscfn_cmd_if.sv =====
// ----------------------------------------------------------------------------
// bscfn_cmd_if
// Command channel: valid/ready handshake carrying a command and a bit index.
// ----------------------------------------------------------------------------
interface bscfn_cmd_if;
	logic        valid;
	logic        ready;
	logic [2:0]  cmd;
	logic [12:0] index;

	modport source (output valid, output cmd, output index, input ready);
	modport sink   (input valid, input cmd, input index, output ready);
endinterface

// ===== rtl/core/bscfn_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bscfn_rsp_if
// Response channel: valid/ready handshake carrying one command's result.
// ----------------------------------------------------------------------------
interface bscfn_rsp_if;
	logic        valid;
	logic        ready;
	logic        bit_value;
	logic        found;
	logic [12:0] found_index;
	logic [13:0] ones_count;
	logic        lowest_valid;
	logic [12:0] lowest_index;

	modport source (output valid, output bit_value, output found, output found_index,
		output ones_count, output lowest_valid, output lowest_index, input ready);
	modport sink   (input valid, input bit_value, input found, input found_index,
		input ones_count, input lowest_valid, input lowest_index, output ready);
endinterface

// ===== rtl/core/bitmap_set_clear_find_next.sv =====
// ----------------------------------------------------------------------------
// bitmap_set_clear_find_next
// Bit map with get/set/clear, find-next-set, clear-all, running count and
// tracked lowest set index.
// ----------------------------------------------------------------------------
// The map is held in a single-port-write, registered-read RAM of 64-bit words
// (VECTOR_BITS/64 rows, 128 at the default size). One command is in flight at
// a time. Get, set, clear and an unknown command pass from accept through RAM
// read, update and result register. Find-next above the tracked lowest set
// index and a clear of the lowest set bit run the shared word scanner: the
// addressed word is checked in the update cycle, then one further word per
// cycle is read and checked, stepping over at most VECTOR_BITS/64 - 1 empty
// words. Clear-all sweeps zeros through every row. After reset the same sweep
// runs before the first command is taken. A finished result waits in the
// output register; the next command is taken meanwhile and only its result
// stalls behind it.
module bitmap_set_clear_find_next #(
	parameter int VECTOR_BITS = 8192
) (
	input  logic         clk,
	input  logic         arst_n,
	bscfn_cmd_if.sink    req,
	bscfn_rsp_if.source  rsp
);
	import bscfn_pkg::*;

	localparam int NWORDS = (VECTOR_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int WAW    = (NWORDS > 1) ? $clog2(NWORDS) : 1;

	typedef logic [WAW-1:0] waddr_t;

	localparam waddr_t LAST_WORD = WAW'(NWORDS - 1);

	word_t mem [NWORDS];
	word_t rd_data_q;

	state_t state_q, state_d;
	waddr_t ptr_q, ptr_d;
	count_t cnt_q, cnt_d;
	index_t first_q, first_d;
	logic   first_v_q, first_v_d;
	logic   out_valid_q, out_valid_d;

	cmd_t   cmd_q, cmd_d;
	index_t idx_q, idx_d;
	logic   res_bit_q, res_bit_d;
	logic   res_found_q, res_found_d;
	index_t res_fidx_q, res_fidx_d;

	logic   load_out;
	logic   bit_value_q, found_q, lowest_valid_q;
	index_t found_index_q, lowest_index_q;
	count_t ones_count_q;

	logic   wr_en;
	waddr_t wr_addr, rd_addr;
	word_t  wr_data;

	logic   in_range;
	waddr_t word_sel;
	off_t   off;
	word_t  bit_mask, hi_mask, cleared, scan_word;
	logic   cur_bit, scan_go, scan_hit, last_word;
	waddr_t scan_addr;
	index_t scan_pos;

	assign in_range  = 32'(idx_q) < VECTOR_BITS;
	assign word_sel  = WAW'(idx_q >> OFF_BITS);
	assign off       = idx_q[OFF_BITS-1:0];
	assign bit_mask  = {{(WORD_BITS-1){1'b0}}, 1'b1} << off;
	assign hi_mask   = {WORD_BITS{1'b1}} << off;
	assign cur_bit   = |(rd_data_q & bit_mask);
	assign cleared   = rd_data_q & ~bit_mask;

	// shared scanner: first word is the addressed one masked from the start bit
	always_comb begin
		if (state_q == ST_OP) begin
			scan_word = ((cmd_q == CMD_CLEAR) ? cleared : rd_data_q) & hi_mask;
			scan_addr = word_sel;
		end else begin
			scan_word = rd_data_q;
			scan_addr = ptr_q;
		end
	end

	assign scan_hit  = |scan_word;
	assign scan_pos  = INDEX_BITS'({scan_addr, first_set(scan_word)});
	assign last_word = scan_addr == LAST_WORD;

	assign req.ready = state_q == ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			ptr_q       <= '0;
			cnt_q       <= '0;
			first_q     <= '0;
			first_v_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			ptr_q       <= ptr_d;
			cnt_q       <= cnt_d;
			first_q     <= first_d;
			first_v_q   <= first_v_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q       <= cmd_d;
		idx_q       <= idx_d;
		res_bit_q   <= res_bit_d;
		res_found_q <= res_found_d;
		res_fidx_q  <= res_fidx_d;
		if (load_out) begin
			bit_value_q    <= res_bit_q;
			found_q        <= res_found_q;
			found_index_q  <= res_fidx_q;
			ones_count_q   <= cnt_q;
			lowest_valid_q <= first_v_q;
			lowest_index_q <= first_v_q ? first_q : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_comb begin
		state_d     = state_q;
		ptr_d       = ptr_q;
		cnt_d       = cnt_q;
		first_d     = first_q;
		first_v_d   = first_v_q;
		cmd_d       = cmd_q;
		idx_d       = idx_q;
		res_bit_d   = res_bit_q;
		res_found_d = res_found_q;
		res_fidx_d  = res_fidx_q;
		wr_en       = 1'b0;
		wr_addr     = word_sel;
		wr_data     = '0;
		rd_addr     = word_sel;
		scan_go     = 1'b0;
		load_out    = 1'b0;

		case (state_q)
			ST_INIT, ST_CLR: begin
				wr_en   = 1'b1;
				wr_addr = ptr_q;
				ptr_d   = ptr_q + 1'b1;
				if (ptr_q == LAST_WORD) begin
					state_d = (state_q == ST_INIT) ? ST_IDLE : ST_DONE;
				end
			end
			ST_IDLE: begin
				if (req.valid) begin
					cmd_d       = cmd_t'(req.cmd);
					idx_d       = req.index;
					res_bit_d   = 1'b0;
					res_found_d = 1'b0;
					res_fidx_d  = '0;
					if (cmd_t'(req.cmd) == CMD_CLEAR_ALL) begin
						ptr_d     = '0;
						cnt_d     = '0;
						first_d   = '0;
						first_v_d = 1'b0;
						state_d   = ST_CLR;
					end else begin
						state_d = ST_RD;
					end
				end
			end
			ST_RD: begin
				state_d = ST_OP;
			end
			ST_OP: begin
				state_d = ST_DONE;
				case (cmd_q)
					CMD_GET: begin
						res_bit_d = in_range & cur_bit;
					end
					CMD_SET: begin
						if (in_range) begin
							wr_en   = 1'b1;
							wr_data = rd_data_q | bit_mask;
							if (!cur_bit) begin
								cnt_d = cnt_q + 1'b1;
							end
							if (!first_v_q || idx_q < first_q) begin
								first_d   = idx_q;
								first_v_d = 1'b1;
							end
						end
					end
					CMD_CLEAR: begin
						if (in_range && cur_bit) begin
							wr_en   = 1'b1;
							wr_data = cleared;
							cnt_d   = cnt_q - 1'b1;
							scan_go = first_v_q && (idx_q == first_q);
						end
					end
					CMD_FIND: begin
						if (in_range && first_v_q) begin
							if (idx_q <= first_q) begin
								res_found_d = 1'b1;
								res_fidx_d  = first_q;
							end else begin
								scan_go = 1'b1;
							end
						end
					end
					default: ;
				endcase
			end
			ST_SCAN: begin
				scan_go = 1'b1;
			end
			ST_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// word scan step: resolve on a hit or at the top, else fetch the next word
		if (scan_go) begin
			if (scan_hit || last_word) begin
				state_d = ST_DONE;
				if (cmd_q == CMD_CLEAR) begin
					first_v_d = scan_hit;
					first_d   = scan_hit ? scan_pos : '0;
				end else begin
					res_found_d = scan_hit;
					res_fidx_d  = scan_hit ? scan_pos : '0;
				end
			end else begin
				rd_addr = scan_addr + 1'b1;
				ptr_d   = scan_addr + 1'b1;
				state_d = ST_SCAN;
			end
		end

		if (load_out) begin
			out_valid_d = 1'b1;
		end else if (rsp.ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.bit_value    = bit_value_q;
	assign rsp.found        = found_q;
	assign rsp.found_index  = found_index_q;
	assign rsp.ones_count   = ones_count_q;
	assign rsp.lowest_valid = lowest_valid_q;
	assign rsp.lowest_index = lowest_index_q;

endmodule

// ===== rtl/core/bscfn_checker.sv =====
// ----------------------------------------------------------------------------
// bscfn_checker
// Port-level checks for the bit map block, bound to its top level.
// ----------------------------------------------------------------------------
module bscfn_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   req_valid,
	input logic                   req_ready,
	input logic                   rsp_valid,
	input logic                   rsp_ready,
	input logic                   found,
	input bscfn_pkg::index_t      found_index,
	input bscfn_pkg::count_t      ones_count,
	input logic                   lowest_valid,
	input bscfn_pkg::index_t      lowest_index
);
	import bscfn_pkg::*;

	// a result, once shown, stays until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped before it was taken");

	// one command in flight: ready drops right after a transaction
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("command taken while another is in flight");

	a_lowest_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !lowest_valid |-> lowest_index == '0)
		else $error("lowest index nonzero on an empty map");

	a_count_lowest: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> lowest_valid == (ones_count != '0))
		else $error("lowest valid disagrees with the set count");

	a_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !found |-> found_index == '0)
		else $error("found index nonzero without a hit");

endmodule

bind bitmap_set_clear_find_next bscfn_checker u_bscfn_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.found        (rsp.found),
	.found_index  (rsp.found_index),
	.ones_count   (rsp.ones_count),
	.lowest_valid (rsp.lowest_valid),
	.lowest_index (rsp.lowest_index)
);
